// File: rtl/dlbe_pkg.sv
`default_nettype none
package dlbe_pkg;

  // Serializer geometry
  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned BIT_CNT_W     = 4;
  localparam int unsigned PHASE_W       = 8;
  localparam int unsigned GAP_W         = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [7:0]       ZERO_HIGH_RST  = 8'd20;
  localparam logic [7:0]       ONE_HIGH_RST   = 8'd40;
  localparam logic [7:0]       PERIOD_RST     = 8'd62;
  localparam logic [GAP_W-1:0] GAP_RST        = 16'd2500;
  localparam logic             DUAL_EN_RST    = 1'b0;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_HIGH = 3'd0,
    CFG_ONE_HIGH  = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_GAP       = 3'd3,
    CFG_DUAL_EN   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_kind_t;

  // One classified item as held in the queue
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       frame_end;
  } op_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage
`default_nettype wire

// File: rtl/dlbe_in_if.sv
`default_nettype none
interface dlbe_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic       frame_end;

  modport source (output valid, output kind, output byte_a, output byte_b,
                  output frame_end, input ready);
  modport sink   (input valid, input kind, input byte_a, input byte_b,
                  input frame_end, output ready);
endinterface
`default_nettype wire

// File: rtl/dlbe_out_if.sv
`default_nettype none
interface dlbe_out_if;
  logic valid;
  logic ready;
  logic pin_a;
  logic pin_b;
  logic accepted;
  logic busy_res;

  modport source (output valid, output pin_a, output pin_b, output accepted,
                  output busy_res, input ready);
  modport sink   (input valid, input pin_a, input pin_b, input accepted,
                  input busy_res, output ready);
endinterface
`default_nettype wire

// File: rtl/dlbe_front.sv
`default_nettype none
module dlbe_front #(
  parameter int unsigned QUEUE_DEPTH = dlbe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dlbe_in_if.sink                in_if,
  input  wire logic              pop,
  output dlbe_pkg::q_head_t      head
);
  import dlbe_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  op_t              q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  op_t              op_in;
  logic             push;
  logic             do_pop;

  // Classify the incoming item
  always_comb begin
    op_in.kind      = in_if.kind ? OP_TICK : OP_LOAD;
    op_in.byte_a    = in_if.byte_a;
    op_in.byte_b    = in_if.byte_b;
    op_in.frame_end = in_if.frame_end;
  end

  assign in_if.ready = (count_r != CNT_FULL);
  assign push        = in_if.valid && in_if.ready;
  assign do_pop      = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.op    = q_mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dlbe_back.sv
`default_nettype none
module dlbe_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [dlbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dlbe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  dlbe_pkg::q_head_t                       head,
  output logic                                    pop,
  dlbe_out_if.source                              out_if
);
  import dlbe_pkg::*;

  // Configuration registers
  logic [7:0]       zero_high_r;
  logic [7:0]       one_high_r;
  logic [7:0]       period_r;
  logic [GAP_W-1:0] gap_len_r;
  logic             dual_en_r;

  // Waveform state
  logic [7:0]           shift_a_r,   shift_a_nxt;
  logic [7:0]           shift_b_r,   shift_b_nxt;
  logic [BIT_CNT_W-1:0] bits_left_r, bits_left_nxt;
  logic [PHASE_W-1:0]   phase_r,     phase_nxt;
  logic                 last_r,      last_nxt;
  logic                 hold_vld_r,  hold_vld_nxt;
  logic [7:0]           hold_a_r,    hold_a_nxt;
  logic [7:0]           hold_b_r,    hold_b_nxt;
  logic                 hold_end_r,  hold_end_nxt;
  logic [GAP_W-1:0]     gap_r,       gap_nxt;
  logic [1:0]           lines_r,     lines_nxt;
  logic                 acc;

  // Output register
  logic out_vld_r;
  logic pin_a_r, pin_b_r, acc_r, busy_r;

  // High level of one lane at a given phase, high count clipped to period
  function automatic logic lane_level(input logic msb, input logic [7:0] zero_hi,
                                      input logic [7:0] one_hi, input logic [7:0] per,
                                      input logic [7:0] ph);
    logic [7:0] hi;
    hi = msb ? one_hi : zero_hi;
    if (hi > per) begin
      hi = per;
    end
    return ph < hi;
  endfunction

  assign pop = head.valid && (!out_vld_r || out_if.ready);

  // Execute one item against the waveform state
  always_comb begin
    logic       start;
    logic [8:0] ph_inc;
    logic       la, lb;
    shift_a_nxt   = shift_a_r;
    shift_b_nxt   = shift_b_r;
    bits_left_nxt = bits_left_r;
    phase_nxt     = phase_r;
    last_nxt      = last_r;
    hold_vld_nxt  = hold_vld_r;
    hold_a_nxt    = hold_a_r;
    hold_b_nxt    = hold_b_r;
    hold_end_nxt  = hold_end_r;
    gap_nxt       = gap_r;
    lines_nxt     = lines_r;
    acc           = 1'b0;
    la            = 1'b0;
    lb            = 1'b0;
    start         = 1'b0;
    ph_inc        = '0;
    case (head.op.kind)
      OP_LOAD: begin
        if (!hold_vld_r) begin
          hold_a_nxt   = head.op.byte_a;
          hold_b_nxt   = head.op.byte_b;
          hold_end_nxt = head.op.frame_end;
          hold_vld_nxt = 1'b1;
          acc          = 1'b1;
        end
      end
      OP_TICK: begin
        // Pull the buffered pair into the shifters when the line is free
        start = (bits_left_r == '0) && (gap_r == '0) && hold_vld_r;
        if (start) begin
          shift_a_nxt   = hold_a_r;
          shift_b_nxt   = hold_b_r;
          last_nxt      = hold_end_r;
          bits_left_nxt = BIT_CNT_W'(BITS_PER_BYTE);
          phase_nxt     = '0;
          hold_vld_nxt  = 1'b0;
        end
        if (bits_left_nxt != '0) begin
          la = lane_level(shift_a_nxt[7], zero_high_r, one_high_r, period_r, phase_nxt);
          lb = dual_en_r &&
               lane_level(shift_b_nxt[7], zero_high_r, one_high_r, period_r, phase_nxt);
          ph_inc = {1'b0, phase_nxt} + 9'd1;
          if (ph_inc >= {1'b0, period_r}) begin
            // End of bit period
            phase_nxt     = '0;
            shift_a_nxt   = {shift_a_nxt[6:0], 1'b0};
            shift_b_nxt   = {shift_b_nxt[6:0], 1'b0};
            bits_left_nxt = bits_left_nxt - BIT_CNT_W'(1);
            if ((bits_left_nxt == '0) && last_nxt) begin
              gap_nxt = gap_len_r;
            end
          end else begin
            phase_nxt = ph_inc[PHASE_W-1:0];
          end
        end else if (gap_r != '0) begin
          gap_nxt = gap_r - GAP_W'(1);
        end
        lines_nxt = {lb, la};
      end
      default: begin
      end
    endcase
  end

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= ZERO_HIGH_RST;
      one_high_r  <= ONE_HIGH_RST;
      period_r    <= PERIOD_RST;
      gap_len_r   <= GAP_RST;
      dual_en_r   <= DUAL_EN_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ZERO_HIGH: zero_high_r <= cfg_data[7:0];
        CFG_ONE_HIGH:  one_high_r  <= cfg_data[7:0];
        CFG_PERIOD:    period_r    <= cfg_data[7:0];
        CFG_GAP:       gap_len_r   <= cfg_data[GAP_W-1:0];
        CFG_DUAL_EN:   dual_en_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // State update on each executed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_a_r   <= '0;
      shift_b_r   <= '0;
      bits_left_r <= '0;
      phase_r     <= '0;
      last_r      <= 1'b0;
      hold_vld_r  <= 1'b0;
      hold_a_r    <= '0;
      hold_b_r    <= '0;
      hold_end_r  <= 1'b0;
      gap_r       <= '0;
      lines_r     <= '0;
    end else if (pop) begin
      shift_a_r   <= shift_a_nxt;
      shift_b_r   <= shift_b_nxt;
      bits_left_r <= bits_left_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      hold_vld_r  <= hold_vld_nxt;
      hold_a_r    <= hold_a_nxt;
      hold_b_r    <= hold_b_nxt;
      hold_end_r  <= hold_end_nxt;
      gap_r       <= gap_nxt;
      lines_r     <= lines_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (pop) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pin_a_r <= lines_nxt[0];
      pin_b_r <= lines_nxt[1];
      acc_r   <= acc;
      busy_r  <= (bits_left_nxt != '0) || (gap_nxt != '0) || hold_vld_nxt;
    end
  end

  assign out_if.valid    = out_vld_r;
  assign out_if.pin_a    = pin_a_r;
  assign out_if.pin_b    = pin_b_r;
  assign out_if.accepted = acc_r;
  assign out_if.busy_res = busy_r;

endmodule
`default_nettype wire

// File: rtl/dual_lane_led_bit_encoder_top.sv
// Dual-lane one-wire LED encoder.
// in_if carries items: kind 0 loads byte_a/byte_b/frame_end into a one-entry
// holding buffer, kind 1 is one tick of the waveform timebase. out_if returns
// one result per item: pin levels after the item, whether a load was taken,
// and whether the encoder is still busy. Each transfer is valid && ready.
// cfg_we/cfg_index/cfg_data write the timing registers (high counts, bit
// period, reset gap, lane B enable); write them only while idle.
// Path: with the queue empty, an item is first written into the front queue,
// then executed and captured in the result register, where it waits for ready.
// Throughput: one item per cycle while out_if does not stall, set by the state
// update in the back end; the front queue holds QUEUE_DEPTH items.
// Reset (rst_n low, synchronous) clears the queue, result valid flag and all
// waveform state, and loads the default timing registers; no clearing pass.
// When out_if stalls, the result register holds and the queue keeps taking
// items until it is full, then in_if.ready drops.
`default_nettype none
module dual_lane_led_bit_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = dlbe_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dlbe_in_if.sink                              in_if,
  dlbe_out_if.source                           out_if,
  input  wire logic                            cfg_we,
  input  wire logic [dlbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dlbe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dlbe_pkg::*;

  q_head_t head;
  logic    pop;

  // Accept and classify, queue
  dlbe_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .pop   (pop),
    .head  (head)
  );

  // Waveform engine and result register
  dlbe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire
